FILE: rtl/mptc_pkg.sv
// Package: request/result types, verdict codes and the magic-byte row table.
`timescale 1ns / 1ps
package mptc_pkg;

	localparam int ROWS = 34;
	localparam int PAT_MAX = 11;
	localparam logic [5:0] NO_ROW = 6'd34;
	localparam logic [9:0] POS_MAX = 10'd1023;
	localparam logic [10:0] HEAD_LIMIT = 11'd512;
	localparam int PADDR_W = 3;

	// register byte addresses
	localparam logic [PADDR_W-1:0] REG_DECLARED_TYPE = 3'd0;

	typedef enum logic [1:0] {
		VERDICT_UNKNOWN     = 2'd0,
		VERDICT_AGREES      = 2'd1,
		VERDICT_CONTRADICTS = 2'd2
	} verdict_t;

	typedef struct packed {
		logic       has_byte;
		logic [7:0] data_byte;
		logic       last_byte;
	} req_t;

	typedef struct packed {
		logic [1:0] verdict;
		logic [5:0] matched_row;
	} res_t;

	// match state as seen by the verdict logic
	typedef struct packed {
		logic [ROWS-1:0] alive;
		logic [9:0]      pos;
	} scan_t;

	localparam logic [8:0] ROW_OFF [ROWS] = '{
		9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd8,
		9'd8, 9'd8, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd4, 9'd4, 9'd0,
		9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd257, 9'd0,
		9'd0, 9'd0, 9'd0, 9'd0
	};

	localparam logic [3:0] ROW_LEN [ROWS] = '{
		4'd8, 4'd3, 4'd6, 4'd6, 4'd2, 4'd4, 4'd4, 4'd4, 4'd5, 4'd4,
		4'd4, 4'd4, 4'd4, 4'd4, 4'd3, 4'd2, 4'd4, 4'd6, 4'd4, 4'd4,
		4'd5, 4'd11, 4'd4, 4'd3, 4'd3, 4'd6, 4'd6, 4'd6, 4'd5, 4'd4,
		4'd4, 4'd4, 4'd4, 4'd4
	};

	localparam logic [4:0] ROW_TYPE [ROWS] = '{
		5'd1, 5'd2, 5'd3, 5'd3, 5'd4, 5'd5, 5'd6, 5'd6, 5'd7, 5'd8,
		5'd9, 5'd10, 5'd11, 5'd12, 5'd13, 5'd13, 5'd14, 5'd15, 5'd16, 5'd17,
		5'd18, 5'd19, 5'd20, 5'd21, 5'd22, 5'd23, 5'd24, 5'd25, 5'd26, 5'd27,
		5'd28, 5'd29, 5'd30, 5'd31
	};

	// svg, webm, zip, gzip, bzip2, xz, 7z, rar, tar
	localparam logic [ROWS-1:0] ROW_CONTAINER =
		34'b00_0001_1111_1100_0001_0000_0001_0000_0000;

	localparam logic [7:0] ROW_PAT [ROWS][PAT_MAX] = '{
		'{8'h89, 8'h50, 8'h4E, 8'h47, 8'h0D, 8'h0A, 8'h1A, 8'h0A, 8'h00, 8'h00, 8'h00},
		'{8'hFF, 8'hD8, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h47, 8'h49, 8'h46, 8'h38, 8'h37, 8'h61, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h47, 8'h49, 8'h46, 8'h38, 8'h39, 8'h61, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h42, 8'h4D, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h00, 8'h00, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h49, 8'h49, 8'h2A, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h4D, 8'h4D, 8'h00, 8'h2A, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h3C, 8'h3F, 8'h78, 8'h6D, 8'h6C, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h57, 8'h45, 8'h42, 8'h50, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h57, 8'h41, 8'h56, 8'h45, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h41, 8'h56, 8'h49, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h4F, 8'h67, 8'h67, 8'h53, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h66, 8'h4C, 8'h61, 8'h43, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h49, 8'h44, 8'h33, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'hFF, 8'hFB, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h1A, 8'h45, 8'hDF, 8'hA3, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h66, 8'h74, 8'h79, 8'h70, 8'h71, 8'h74, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h66, 8'h74, 8'h79, 8'h70, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h00, 8'h00, 8'h01, 8'hBA, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h25, 8'h50, 8'h44, 8'h46, 8'h2D, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h25, 8'h21, 8'h50, 8'h53, 8'h2D, 8'h41, 8'h64, 8'h6F, 8'h62, 8'h65, 8'h2D},
		'{8'h50, 8'h4B, 8'h03, 8'h04, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h1F, 8'h8B, 8'h08, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h42, 8'h5A, 8'h68, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'hFD, 8'h37, 8'h7A, 8'h58, 8'h5A, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h37, 8'h7A, 8'hBC, 8'hAF, 8'h27, 8'h1C, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h52, 8'h61, 8'h72, 8'h21, 8'h1A, 8'h07, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h75, 8'h73, 8'h74, 8'h61, 8'h72, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h00, 8'h61, 8'h73, 8'h6D, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h77, 8'h4F, 8'h46, 8'h46, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h77, 8'h4F, 8'h46, 8'h32, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h4F, 8'h54, 8'h54, 8'h4F, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h00, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
	};

endpackage

FILE: rtl/magic_pattern_type_check_core.sv
// Top level: request register, match state, verdict logic, result register and APB port.
// Path: request register, then result register (loaded with last-byte verdicts).
// Throughput: one request per cycle; the request register stalls only when it holds a
//   last-byte request and the result register is full and stalled.
// Reset (arst_n low, asynchronous): request/result valids clear, alive mask all ones,
//   byte count zero, declared_type zero. No clearing pass.
`timescale 1ns / 1ps
module magic_pattern_type_check_core (
	input  logic                          clk,
	input  logic                          arst_n,
	// request channel
	input  logic                          req_valid,
	output logic                          req_stall,
	input  mptc_pkg::req_t                req,
	// result channel
	output logic                          res_valid,
	input  logic                          res_stall,
	output mptc_pkg::res_t                res,
	// APB configuration port
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [mptc_pkg::PADDR_W-1:0]  paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);
	import mptc_pkg::*;

	// request register
	logic  valid_s1;
	req_t  req_s1;
	// result register
	logic  res_valid_q;
	res_t  res_q;
	// config
	logic [4:0] declared_type_q;

	logic    out_free;
	logic    advance;
	logic    load_res;
	scan_t   scan_cur;
	scan_t   scan_nxt;
	res_t    res_nxt;

	// Result slot is free when empty or being taken this cycle.
	assign out_free = !res_valid_q || !res_stall;
	// Requests without last_byte need no result slot and always move on.
	assign advance = valid_s1 && (!req_s1.last_byte || out_free);
	assign load_res = advance && req_s1.last_byte;
	assign req_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!req_stall) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			req_s1 <= req;
		end
	end

	// Per-row compare and state update.
	mptc_match u_match (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (advance),
		.req_s1   (req_s1),
		.scan_cur (scan_cur),
		.scan_nxt (scan_nxt)
	);

	// Verdict on the state as it stands after this request's byte.
	mptc_verdict u_verdict (
		.scan          (scan_nxt),
		.declared_type (declared_type_q),
		.res           (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (load_res) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_res) begin
			res_q <= res_nxt;
		end
	end

	assign res_valid = res_valid_q;
	assign res = res_q;

	// APB: single register, zero wait states. User writes only while idle; not enforced.
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			declared_type_q <= '0;
		end else if (psel && penable && pwrite && paddr[2] == REG_DECLARED_TYPE[2]) begin
			declared_type_q <= pwdata[4:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_DECLARED_TYPE[2]) begin
			prdata = {27'd0, declared_type_q};
		end
	end

	// A held request must not be overwritten.
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> (valid_s1 && $stable(req_s1)))
		else $error("held request lost");

	// Giving a verdict restarts the match state.
	assert property (@(posedge clk) disable iff (!arst_n)
		load_res |=> (scan_cur.pos == 10'd0 && (&scan_cur.alive)))
		else $error("match state not restarted after verdict");

	// An agreeing verdict always names a real row.
	assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_q.verdict == VERDICT_AGREES) |-> (res_q.matched_row != NO_ROW))
		else $error("agree verdict without matched row");

	// A result is loaded only when the slot is free.
	assert property (@(posedge clk) disable iff (!arst_n)
		load_res |-> out_free)
		else $error("result overwritten");

endmodule

FILE: rtl/mptc_match.sv
// Per-row byte compare: holds the alive mask and byte count, gives the post-byte state.
`timescale 1ns / 1ps
module mptc_match (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          step,
	input  mptc_pkg::req_t req_s1,
	output mptc_pkg::scan_t scan_cur,
	output mptc_pkg::scan_t scan_nxt
);
	import mptc_pkg::*;

	logic [ROWS-1:0] alive_q;
	logic [9:0]      pos_q;

	always_comb begin
		logic [9:0] k;
		k = '0;
		scan_nxt.alive = alive_q;
		scan_nxt.pos = pos_q;
		if (req_s1.has_byte) begin
			for (int r = 0; r < ROWS; r++) begin
				if (pos_q >= 10'(ROW_OFF[r])) begin
					k = pos_q - 10'(ROW_OFF[r]);
					if (k < 10'(ROW_LEN[r])) begin
						if (ROW_PAT[r][k[3:0]] != req_s1.data_byte) begin
							scan_nxt.alive[r] = 1'b0;
						end
					end
				end
			end
			if (pos_q < POS_MAX) begin
				scan_nxt.pos = pos_q + 10'd1;
			end
		end
	end

	assign scan_cur.alive = alive_q;
	assign scan_cur.pos = pos_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alive_q <= '1;
			pos_q <= '0;
		end else if (step) begin
			if (req_s1.last_byte) begin
				// verdict given: start over for the next body
				alive_q <= '1;
				pos_q <= '0;
			end else begin
				alive_q <= scan_nxt.alive;
				pos_q <= scan_nxt.pos;
			end
		end
	end

endmodule

FILE: rtl/mptc_verdict.sv
// Verdict logic: first matching row and the agree/contradict decision.
`timescale 1ns / 1ps
module mptc_verdict (
	input  mptc_pkg::scan_t scan,
	input  logic [4:0]      declared_type,
	output mptc_pkg::res_t  res
);
	import mptc_pkg::*;

	logic [5:0] hit;
	logic       known;

	// priority pick, lowest row wins
	always_comb begin
		hit = NO_ROW;
		for (int r = ROWS - 1; r >= 0; r--) begin
			if (scan.alive[r] && scan.pos >= 10'(ROW_OFF[r]) + 10'(ROW_LEN[r])) begin
				hit = 6'(r);
			end
		end
	end

	assign known = (declared_type != 5'd0);

	always_comb begin
		res.matched_row = hit;
		res.verdict = VERDICT_UNKNOWN;
		if (hit != NO_ROW) begin
			if (ROW_TYPE[hit] == declared_type) begin
				res.verdict = VERDICT_AGREES;
			end else if (known || !ROW_CONTAINER[hit]) begin
				res.verdict = VERDICT_CONTRADICTS;
			end
		end else if (known && {1'b0, scan.pos} >= HEAD_LIMIT) begin
			res.verdict = VERDICT_CONTRADICTS;
		end
	end

endmodule

FILE: tb/sv/sniff_tb_pkg.sv
// Testbench package: magic-byte table copy and the verdict scoreboard class.
`timescale 1ns / 1ps
package sniff_tb_pkg;
	import mptc_pkg::*;

	localparam int ROW_COUNT = 34;
	localparam int NONE_MATCHED = 34;
	localparam int HEAD_SAT = 1023;
	localparam int HEAD_LIMIT_BYTES = 512;

	// signatures right-justified: byte k of a row sits at bits 8*(len-1-k)
	localparam logic [87:0] SIG [ROW_COUNT] = '{
		88'h89504E470D0A1A0A, 88'hFFD8FF, 88'h474946383761, 88'h474946383961,
		88'h424D, 88'h00000100, 88'h49492A00, 88'h4D4D002A, 88'h3C3F786D6C,
		88'h57454250, 88'h57415645, 88'h41564920, 88'h4F676753, 88'h664C6143,
		88'h494433, 88'hFFFB, 88'h1A45DFA3, 88'h667479707174, 88'h66747970,
		88'h000001BA, 88'h255044462D, 88'h2521_5053_2D41_646F_6265_2D,
		88'h504B0304, 88'h1F8B08, 88'h425A68, 88'hFD377A585A00, 88'h377ABCAF271C,
		88'h526172211A07, 88'h7573746172, 88'h0061736D, 88'h774F4646, 88'h774F4632,
		88'h4F54544F, 88'h00010000
	};

	localparam int SIG_OFF [ROW_COUNT] = '{
		0, 0, 0, 0, 0, 0, 0, 0, 0, 8, 8, 8, 0, 0, 0, 0, 0,
		4, 4, 0, 0, 0, 0, 0, 0, 0, 0, 0, 257, 0, 0, 0, 0, 0
	};

	localparam int SIG_LEN [ROW_COUNT] = '{
		8, 3, 6, 6, 2, 4, 4, 4, 5, 4, 4, 4, 4, 4, 3, 2, 4,
		6, 4, 4, 5, 11, 4, 3, 3, 6, 6, 6, 5, 4, 4, 4, 4, 4
	};

	localparam int SIG_TYPE [ROW_COUNT] = '{
		1, 2, 3, 3, 4, 5, 6, 6, 7, 8, 9, 10, 11, 12, 13, 13, 14,
		15, 16, 17, 18, 19, 20, 21, 22, 23, 24, 25, 26, 27, 28, 29, 30, 31
	};

	// svg, webm, zip, gzip, bzip2, xz, 7z, rar, tar
	localparam logic [ROW_COUNT-1:0] SIG_CONTAINER =
		(34'd1 << 8) | (34'd1 << 16) | (34'd1 << 22) | (34'd1 << 23) | (34'd1 << 24) |
		(34'd1 << 25) | (34'd1 << 26) | (34'd1 << 27) | (34'd1 << 28);

	function automatic logic [7:0] sig_byte(int r, int k);
		return SIG[r][8*(SIG_LEN[r]-1-k) +: 8];
	endfunction

	class verdict_board;
		logic [4:0] declared;
		logic [9:0] head_count;
		logic [ROW_COUNT-1:0] alive;
		res_t verdicts_due[$];
		int fails;

		function new();
			declared = '0;
			head_count = '0;
			alive = '1;
			fails = 0;
		endfunction

		function void set_declared(logic [4:0] t);
			declared = t;
		endfunction

		function void complain(string msg);
			if (fails < 10) begin
				$display("%s", msg);
			end
			fails++;
		endfunction

		function void take_byte(logic [7:0] b);
			int k;
			for (int r = 0; r < ROW_COUNT; r++) begin
				if (head_count >= SIG_OFF[r]) begin
					k = head_count - SIG_OFF[r];
					if (k < SIG_LEN[r] && sig_byte(r, k) != b) begin
						alive[r] = 1'b0;
					end
				end
			end
			if (head_count != HEAD_SAT) begin
				head_count++;
			end
		endfunction

		// first live, fully seen row decides
		function res_t judge_head();
			res_t v;
			v.verdict = VERDICT_UNKNOWN;
			v.matched_row = 6'(NONE_MATCHED);
			for (int r = 0; r < ROW_COUNT; r++) begin
				if (alive[r] && head_count >= SIG_OFF[r] + SIG_LEN[r]) begin
					v.matched_row = 6'(r);
					if (SIG_TYPE[r] == declared) begin
						v.verdict = VERDICT_AGREES;
					end else if (declared != 0 || !SIG_CONTAINER[r]) begin
						v.verdict = VERDICT_CONTRADICTS;
					end
					break;
				end
			end
			if (v.matched_row == NONE_MATCHED && declared != 0 &&
					head_count >= HEAD_LIMIT_BYTES) begin
				v.verdict = VERDICT_CONTRADICTS;
			end
			return v;
		endfunction

		function void note_request(req_t q);
			if (q.has_byte) begin
				take_byte(q.data_byte);
			end
			if (q.last_byte) begin
				verdicts_due.push_back(judge_head());
				head_count = '0;
				alive = '1;
			end
		endfunction

		function void check_result(res_t got);
			res_t want;
			if (verdicts_due.size() == 0) begin
				complain($sformatf("unexpected result: verdict %0d row %0d",
					got.verdict, got.matched_row));
				return;
			end
			want = verdicts_due.pop_front();
			if (got.verdict !== want.verdict || got.matched_row !== want.matched_row) begin
				complain($sformatf("mismatch: expected verdict %0d row %0d, got verdict %0d row %0d",
					want.verdict, want.matched_row, got.verdict, got.matched_row));
			end
		endfunction
	endclass

endpackage

FILE: tb/sv/tb.sv
// Testbench top: drives body bytes and declared-type writes, checks every verdict.
`timescale 1ns / 1ps
module tb;
	import mptc_pkg::*;
	import sniff_tb_pkg::*;

	// worst case is roughly 1300 requests, each possibly delayed by idle gaps and stall bursts
	localparam int LIMIT_CYCLES = 400000;
	localparam int RANDOM_ITEMS = 1050;
	localparam int SETTLE_CYCLES = 4;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	req_t req;
	logic res_valid;
	logic res_stall;
	res_t res;
	logic psel;
	logic penable;
	logic pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	verdict_board sb;
	int items_sent;
	int cycle_count;
	int idle_pct;
	int stall_pct;

	magic_pattern_type_check_core DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res(res),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// watchdog: a hung handshake or a lost verdict ends up here
	initial begin
		cycle_count = 0;
		while (cycle_count < LIMIT_CYCLES) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("tb: failure");
		$finish;
	end

	// Both monitors sample at the rising edge, where the inputs (changed at the
	// falling edge) are settled and the block's outputs still hold pre-edge values.
	always @(posedge clk) begin
		if (arst_n && req_valid && !req_stall) begin
			sb.note_request(req);
		end
		if (arst_n && res_valid && !res_stall) begin
			sb.check_result(res);
		end
	end

	// Result side backpressure: random stall bursts of random length.
	initial begin
		int burst;
		burst = 0;
		res_stall <= 1'b0;
		forever begin
			@(negedge clk);
			if (burst == 0 && stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
				burst = $urandom_range(1, 6);
			end
			res_stall <= (burst != 0);
			if (burst != 0) begin
				burst--;
			end
		end
	end

	// Present one request at a falling edge and hold it until accepted.
	// Returns on the falling edge after acceptance with valid still high,
	// so back-to-back requests never drop valid in between.
	task automatic send_request(req_t q);
		if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
		req <= q;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_stall);
		@(negedge clk);
	endtask

	task automatic push_item(logic has, logic [7:0] b, logic last);
		req_t q;
		q.has_byte = has;
		q.data_byte = b;
		q.last_byte = last;
		if (has || last) begin
			items_sent++;
		end
		send_request(q);
	endtask

	// Block is idle once every verdict is back; a body may still be half
	// consumed (no verdict owed), so give the pipe a few extra cycles.
	task automatic settle();
		req_valid <= 1'b0;
		while (sb.verdicts_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	// APB write of declared_type (junk in the upper bits), then read it back.
	task automatic write_type(logic [4:0] t);
		logic [31:0] w;
		w = $urandom();
		w[4:0] = t;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= REG_DECLARED_TYPE;
		pwdata <= w;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.set_declared(t);
		@(negedge clk);
		pwrite <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata[4:0] !== t) begin
			sb.complain($sformatf("mismatch: declared_type readback expected %0d, got %0d",
				t, prdata[4:0]));
		end
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// One body: either a row's signature at its offset (sometimes corrupted or
	// cut short) or plain random bytes, followed by `tail` random bytes. It
	// ends on the last byte or on an empty end marker, with stray no-byte
	// requests sprinkled in.
	task automatic send_body(int r, int tail);
		logic [7:0] body[$];
		int cut;
		int idx;
		bit marker;
		if (r >= 0) begin
			for (int p = 0; p < SIG_OFF[r] + SIG_LEN[r]; p++) begin
				if (p >= SIG_OFF[r]) begin
					body.push_back(sig_byte(r, p - SIG_OFF[r]));
				end else begin
					body.push_back(8'($urandom_range(0, 255)));
				end
			end
			case ($urandom_range(0, 7))
				0: begin
					idx = $urandom_range(SIG_OFF[r], body.size() - 1);
					body[idx] = body[idx] ^ 8'($urandom_range(1, 255));
				end
				1: begin
					cut = $urandom_range(0, body.size() - 1);
					while (body.size() > cut) void'(body.pop_back());
				end
				default: ;
			endcase
		end
		repeat (tail) body.push_back(8'($urandom_range(0, 255)));
		marker = body.size() == 0 || $urandom_range(0, 3) == 0;
		foreach (body[i]) begin
			if ($urandom_range(0, 9) == 0) begin
				push_item(1'b0, 8'($urandom_range(0, 255)), 1'b0);
			end
			push_item(1'b1, body[i], !marker && i == body.size() - 1);
		end
		if (marker) begin
			push_item(1'b0, 8'($urandom_range(0, 255)), 1'b1);
		end
	endtask

	initial begin
		int phase;
		int base;
		int done;
		int r;
		int pool[$];
		bit calm;
		logic [4:0] t;

		sb = new();
		items_sent = 0;
		idle_pct = 0;
		stall_pct = 0;
		arst_n <= 1'b0;
		req_valid <= 1'b0;
		req <= '0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part, declared_type still at its reset value (unconfirmable).
		push_item(1'b0, 8'hA5, 1'b1);   // empty end marker on an empty head
		push_item(1'b0, 8'h00, 1'b0);   // neither byte nor end: ignored
		push_item(1'b1, 8'hFF, 1'b0);   // jpeg, not a container -> contradicts
		push_item(1'b1, 8'hD8, 1'b0);
		push_item(1'b1, 8'hFF, 1'b1);
		push_item(1'b1, 8'h50, 1'b0);   // zip, a container -> unknown
		push_item(1'b1, 8'h4B, 1'b0);
		push_item(1'b1, 8'h03, 1'b0);
		push_item(1'b1, 8'h04, 1'b0);
		push_item(1'b0, 8'hFF, 1'b1);
		// register change in the middle of a body: verdict takes the new type
		push_item(1'b1, 8'h50, 1'b0);
		push_item(1'b1, 8'h4B, 1'b0);
		push_item(1'b1, 8'h03, 1'b0);
		settle();
		write_type(5'd20);
		push_item(1'b1, 8'h04, 1'b1);
		settle();
		// top type code, ttf signature -> agrees on the last row
		write_type(5'd31);
		push_item(1'b1, 8'h00, 1'b0);
		push_item(1'b1, 8'h01, 1'b0);
		push_item(1'b1, 8'h00, 1'b0);
		push_item(1'b1, 8'h00, 1'b1);
		// known type, one byte, nothing matches, short head -> unknown
		push_item(1'b1, 8'h00, 1'b1);

		// Random part in phases; each phase starts with a fresh declared_type.
		base = items_sent;
		phase = 0;
		done = 0;
		while (done < RANDOM_ITEMS) begin
			calm = done > RANDOM_ITEMS - 120;
			case (phase)
				0: t = 5'd0;
				1: t = 5'd31;
				default: t = 5'($urandom_range(0, 31));
			endcase
			// the head limit phase wants a known type so the limit matters
			if (phase == 2 && t == 0) begin
				t = 5'($urandom_range(1, 31));
			end
			if (phase == 1 && $urandom_range(0, 1) == 0) begin
				t = 5'd26;
			end
			settle();
			write_type(t);
			if (calm) begin
				idle_pct = 0;
				stall_pct = 0;
			end else begin
				case ($urandom_range(0, 2))
					0: idle_pct = 0;
					1: idle_pct = 10;
					default: idle_pct = 35;
				endcase
				case ($urandom_range(0, 2))
					0: stall_pct = 0;
					1: stall_pct = 10;
					default: stall_pct = 35;
				endcase
			end

			// two long heads: tar at offset 257 and the head limit edge
			case (phase)
				1: send_body(28, $urandom_range(0, 3));
				2: send_body(-1, 511 + $urandom_range(0, 1));
				default: ;
			endcase

			repeat ($urandom_range(6, 14)) begin
				pool.delete();
				if (t != 0 && $urandom_range(0, 9) < 4) begin
					for (int k = 0; k < ROW_COUNT; k++) begin
						if (SIG_TYPE[k] == t && k != 28) begin
							pool.push_back(k);
						end
					end
				end
				if (pool.size() != 0) begin
					r = pool[$urandom_range(0, pool.size() - 1)];
				end else if ($urandom_range(0, 9) == 0) begin
					r = -1;
				end else begin
					r = $urandom_range(0, ROW_COUNT - 1);
					if (r == 28) begin
						r = -1;
					end
				end
				send_body(r, r < 0 ? $urandom_range(0, 12) : $urandom_range(0, 5));
			end
			// sometimes leave a body open across the next register write
			if ($urandom_range(0, 3) == 0) begin
				repeat ($urandom_range(1, 4)) push_item(1'b1, 8'($urandom_range(0, 255)), 1'b0);
			end
			phase++;
			done = items_sent - base;
		end

		// Drain: every verdict back, then a few more cycles for strays.
		req_valid <= 1'b0;
		while (sb.verdicts_due.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (sb.fails == 0 && sb.verdicts_due.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

FILE: sim.f
rtl/mptc_pkg.sv
rtl/mptc_match.sv
rtl/mptc_verdict.sv
rtl/magic_pattern_type_check_core.sv
tb/sv/sniff_tb_pkg.sv
tb/sv/tb.sv
